FILE: hdl/ipbe_pkg.sv
package ipbe_pkg;

    // largest value a 13-bit size register can hold
    localparam int CFG_MAX = 8191;

    // configuration register indexes
    localparam logic [1:0] CFG_DEPTH_MODE   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // source pixel depth codes
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;
    localparam logic [1:0] DEPTH_8BPP = 2'd2;

    // request kinds
    localparam logic REQ_PAL = 1'b0;
    localparam logic REQ_PIX = 1'b1;

    // palette store
    localparam int PAL_DEPTH = 256;
    localparam int PAL_WIDTH = 24;

    // job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PW    = 2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
        logic [7:0] src_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       image_end;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [12:0] reg_data;
    } t_cfg_wr;

    // one classified transaction waiting for the back end
    typedef struct packed {
        logic        req_type;
        logic [1:0]  mode;
        logic [7:0]  data;
        logic [23:0] rgb;
        logic [3:0]  count;
        logic        row_hit;
        logic        img_last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic row_end;
        logic image_end;
        logic last;
    } t_tag;

endpackage

FILE: hdl/ipbe_stream_if.sv
interface ipbe_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ipbe_ram.sv
module ipbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/ipbe_front.sv
module ipbe_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  ipbe_pkg::t_cfg_wr    i_cfg,
    output logic                 o_cfg_ready,
    input  logic                 i_req_valid,
    input  ipbe_pkg::t_req       i_req,
    output logic                 o_req_ready,
    input  ipbe_pkg::t_fifo_stat i_stat,
    output logic                 o_push,
    output ipbe_pkg::t_job       o_job
);
    localparam int W_CAP = (MAX_WIDTH < ipbe_pkg::CFG_MAX) ? MAX_WIDTH : ipbe_pkg::CFG_MAX;
    localparam int H_CAP = (MAX_HEIGHT < ipbe_pkg::CFG_MAX) ? MAX_HEIGHT : ipbe_pkg::CFG_MAX;
    localparam int BW    = $clog2(W_CAP + 4);
    localparam int RW    = (H_CAP > 1) ? $clog2(H_CAP) : 1;
    localparam int CW    = (BW + 4 > 17) ? BW + 4 : 17;
    localparam logic [12:0] W_MAX13 = 13'(W_CAP);
    localparam logic [12:0] H_MAX13 = 13'(H_CAP);

    logic [1:0]    r_mode;
    logic [12:0]   r_width;
    logic [12:0]   r_height;
    logic [BW-1:0] r_bir;
    logic [BW-1:0] n_bir;
    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;

    logic [12:0]   w_eff;
    logic [12:0]   h_eff;
    logic [1:0]    bit_sh;
    logic [1:0]    ppb_sh;
    logic [CW-1:0] stride;
    logic [CW-1:0] first;
    logic [CW-1:0] rem;
    logic [CW-1:0] ppb;
    logic          px_left;
    logic [3:0]    count;
    logic          row_hit;
    logic          img_last;
    logic          row_done;
    logic          accept;
    logic          pix_accept;

    // register file, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ipbe_pkg::DEPTH_8BPP;
            r_width  <= 13'd1;
            r_height <= 13'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg.reg_index)
                ipbe_pkg::CFG_DEPTH_MODE:   r_mode   <= i_cfg.reg_data[1:0];
                ipbe_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg.reg_data;
                ipbe_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg.reg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, zero read as one and clamped to the build limits
    always_comb begin
        w_eff = r_width;
        if (r_width == 13'd0) begin
            w_eff = 13'd1;
        end else if (r_width > W_MAX13) begin
            w_eff = W_MAX13;
        end
        h_eff = r_height;
        if (r_height == 13'd0) begin
            h_eff = 13'd1;
        end else if (r_height > H_MAX13) begin
            h_eff = H_MAX13;
        end
    end

    // depth decode: log2 of bits per pixel and of pixels per byte
    always_comb begin
        unique case (r_mode)
            ipbe_pkg::DEPTH_1BPP: begin
                bit_sh = 2'd0;
                ppb_sh = 2'd3;
            end
            ipbe_pkg::DEPTH_4BPP: begin
                bit_sh = 2'd2;
                ppb_sh = 2'd1;
            end
            default: begin
                bit_sh = 2'd3;
                ppb_sh = 2'd0;
            end
        endcase
    end

    // row geometry and pixel count of this byte
    always_comb begin
        stride   = (((CW'(w_eff) << bit_sh) + CW'(31)) >> 5) << 2;
        first    = CW'(r_bir) << ppb_sh;
        ppb      = CW'(1) << ppb_sh;
        px_left  = first < CW'(w_eff);
        rem      = CW'(w_eff) - first;
        count    = 4'd0;
        row_hit  = 1'b0;
        if (px_left) begin
            count   = (rem > ppb) ? 4'(ppb) : 4'(rem);
            row_hit = rem <= ppb;
        end
        img_last = (CW'(r_row) + CW'(1)) >= CW'(h_eff);
        row_done = (CW'(r_bir) + CW'(1)) >= stride;
    end

    assign o_req_ready = !i_stat.full;
    assign accept      = i_req_valid && o_req_ready;
    assign pix_accept  = accept && (i_req.req_type == ipbe_pkg::REQ_PIX);

    // padding bytes only move the row position
    assign o_push = accept && ((i_req.req_type == ipbe_pkg::REQ_PAL) || (count != 4'd0));

    always_comb begin
        o_job.req_type = i_req.req_type;
        o_job.mode     = r_mode;
        o_job.data     = (i_req.req_type == ipbe_pkg::REQ_PAL) ? i_req.pal_index : i_req.src_byte;
        o_job.rgb      = {i_req.pal_red, i_req.pal_green, i_req.pal_blue};
        o_job.count    = count;
        o_job.row_hit  = row_hit;
        o_job.img_last = img_last;
    end

    // row and image position
    always_comb begin
        n_bir = r_bir;
        n_row = r_row;
        if (pix_accept) begin
            if (row_done) begin
                n_bir = '0;
                n_row = img_last ? '0 : RW'(CW'(r_row) + CW'(1));
            end else begin
                n_bir = BW'(CW'(r_bir) + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir <= '0;
            r_row <= '0;
        end else begin
            r_bir <= n_bir;
            r_row <= n_row;
        end
    end

    // a finished row always restarts at its first byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_accept && row_done) |=> (r_bir == '0))
        else $error("byte position not cleared at row end");

    // the row counter restarts after the last row of the image
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_accept && img_last && row_done) |=> (r_row == '0))
        else $error("row counter not cleared at image end");
endmodule

FILE: hdl/ipbe_fifo.sv
module ipbe_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ipbe_pkg::t_job       i_job,
    input  logic                 i_pop,
    output ipbe_pkg::t_job       o_job,
    output ipbe_pkg::t_fifo_stat o_stat
);
    ipbe_pkg::t_job            r_mem [ipbe_pkg::JOB_DEPTH];
    logic [ipbe_pkg::JOB_PW-1:0] r_wp;
    logic [ipbe_pkg::JOB_PW-1:0] r_rp;
    logic [ipbe_pkg::JOB_PW:0]   r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == (ipbe_pkg::JOB_PW + 1)'(ipbe_pkg::JOB_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full job queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty job queue");
endmodule

FILE: hdl/ipbe_back.sv
module ipbe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipbe_pkg::t_job       i_job,
    input  ipbe_pkg::t_fifo_stat i_stat,
    output logic                 o_pop,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output ipbe_pkg::t_res       o_res
);
    localparam int AW = $clog2(ipbe_pkg::PAL_DEPTH);

    logic [2:0]               r_k;
    logic [2:0]               n_k;
    logic                     r_bv;
    logic                     n_bv;
    ipbe_pkg::t_tag           r_tag;
    ipbe_pkg::t_tag           n_tag;
    logic                     can_issue;
    logic                     k_last;
    logic                     ram_we;
    logic                     ram_re;
    logic [7:0]               pix_idx;
    logic [AW-1:0]            raddr;
    logic [ipbe_pkg::PAL_WIDTH-1:0] rdata;

    // palette index of the pixel at position k of the byte
    always_comb begin
        unique case (i_job.mode)
            ipbe_pkg::DEPTH_1BPP: pix_idx = {7'd0, i_job.data[3'd7 - r_k]};
            ipbe_pkg::DEPTH_4BPP: pix_idx = (r_k == 3'd0) ? {4'd0, i_job.data[7:4]}
                                                          : {4'd0, i_job.data[3:0]};
            default:              pix_idx = i_job.data;
        endcase
    end

    assign raddr     = AW'(pix_idx);
    assign can_issue = !r_bv || i_res_ready;
    assign k_last    = ({1'b0, r_k} + 4'd1) == i_job.count;

    // sequencer: palette writes retire at once, bytes issue one read per pixel
    always_comb begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        o_pop  = 1'b0;
        n_k    = r_k;
        n_tag  = r_tag;
        n_bv   = can_issue ? 1'b0 : r_bv;
        if (!i_stat.empty) begin
            if (i_job.req_type == ipbe_pkg::REQ_PAL) begin
                ram_we = 1'b1;
                o_pop  = 1'b1;
            end else if (can_issue) begin
                ram_re          = 1'b1;
                n_bv            = 1'b1;
                n_tag.last      = k_last;
                n_tag.row_end   = k_last && i_job.row_hit;
                n_tag.image_end = k_last && i_job.row_hit && i_job.img_last;
                if (k_last) begin
                    o_pop = 1'b1;
                    n_k   = 3'd0;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= 3'd0;
            r_bv <= 1'b0;
        end else begin
            r_k  <= n_k;
            r_bv <= n_bv;
        end
    end

    // flags travel alongside the registered palette read
    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    ipbe_ram #(
        .WIDTH (ipbe_pkg::PAL_WIDTH),
        .DEPTH (ipbe_pkg::PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_job.data)),
        .i_wdata (i_job.rgb),
        .i_re    (ram_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_res_valid     = r_bv;
    assign o_res.blue      = rdata[7:0];
    assign o_res.green     = rdata[15:8];
    assign o_res.red       = rdata[23:16];
    assign o_res.row_end   = r_tag.row_end;
    assign o_res.image_end = r_tag.image_end;
    assign o_res.last      = r_tag.last;

    // mid-byte position only while that byte is still at the queue head
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 3'd0) |-> (!i_stat.empty && (i_job.req_type == ipbe_pkg::REQ_PIX)))
        else $error("pixel position set without a pending byte");

    // image end only on the closing pixel of a row and of its byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.image_end) |-> (o_res.row_end && o_res.last))
        else $error("image end without row end");
endmodule

FILE: hdl/indexed_pixel_to_bgr_expander_unit.sv
// channel  | dir | payload                                         | transaction
// ---------+-----+-------------------------------------------------+---------------------
// i_req    | in  | req_type, pal_index, pal_red/green/blue, src_byte | valid && ready
// o_res    | out | blue, green, red, row_end, image_end, last      | valid && ready
// i_cfg    | in  | reg_index, reg_data                             | valid && ready
//
// a full source byte gives 8 pixels at 1 bpp, 2 at 4 bpp and 1 at 8 bpp; a padding byte none;
// the palette read port serves one pixel per cycle while the output is not stalled
// padding bytes skip the queue; palette writes retire at its head; pixels pass a read register
// a four-entry job queue lets input run ahead while the output stalls
// reset is synchronous and active low; the palette holds no reset value
module indexed_pixel_to_bgr_expander_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipbe_stream_if.sink          i_req,
    ipbe_stream_if.source        o_res,
    ipbe_stream_if.sink          i_cfg
);
    ipbe_pkg::t_job       push_job;
    ipbe_pkg::t_job       head_job;
    ipbe_pkg::t_fifo_stat stat;
    logic                 push;
    logic                 pop;

    // classify and track row position
    ipbe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .i_req_valid (i_req.valid),
        .i_req       (i_req.data),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decoupling queue
    ipbe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (stat)
    );

    // palette and pixel sequencing
    ipbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_stat      (stat),
        .o_pop       (pop),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (o_res.data)
    );
endmodule

FILE: bench/indexed_pixel_to_bgr_expander_unit_tb.sv
module indexed_pixel_to_bgr_expander_unit_tb;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ITEM_TARGET   = 360;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;

    // register index with no register behind it, and the spare depth code
    localparam logic [1:0] CFG_UNUSED       = 2'd3;
    localparam logic [1:0] DEPTH_MODE_SPARE = 2'd3;

    typedef enum logic {
        STEP_CONFIG,
        STEP_ITEM
    } t_step_kind;

    typedef struct {
        t_step_kind      kind;
        logic [1:0]      reg_index;
        logic [12:0]     reg_data;
        ipbe_pkg::t_req  item;
        logic            use_typed;
        ipbe_pkg::t_res  typed_pixel;
    } t_directed_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipbe_stream_if #(.T(ipbe_pkg::t_req))    req_ch ();
    ipbe_stream_if #(.T(ipbe_pkg::t_res))    res_ch ();
    ipbe_stream_if #(.T(ipbe_pkg::t_cfg_wr)) cfg_ch ();

    indexed_pixel_to_bgr_expander_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted palette, settings and row position
    logic [23:0] palette_copy [ipbe_pkg::PAL_DEPTH];
    bit          palette_written [ipbe_pkg::PAL_DEPTH];
    logic [1:0]  depth_reg   = ipbe_pkg::DEPTH_8BPP;
    logic [12:0] width_reg   = 13'd1;
    logic [12:0] height_reg  = 13'd1;
    logic [11:0] row_byte    = '0;
    logic [12:0] row_index   = '0;

    ipbe_pkg::t_res pending_pixels [$];
    t_directed_step directed_steps [$];

    int unsigned items_sent;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned send_calm;
    int unsigned recv_calm;

    // clock and reset
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int unsigned bits_per_pixel();
        case (depth_reg)
            ipbe_pkg::DEPTH_1BPP: return 1;
            ipbe_pkg::DEPTH_4BPP: return 4;
            default:              return 8;
        endcase
    endfunction

    // zero counts as one, oversize saturates
    function automatic int unsigned clamp_size(logic [12:0] size, int unsigned limit);
        if (size == 0) return 1;
        if (size > limit) return limit;
        return 32'(size);
    endfunction

    // pixels the next source byte carries at the current row position
    function automatic int unsigned pixels_in_byte();
        int unsigned ppb, first, w;
        ppb   = 8 / bits_per_pixel();
        first = row_byte * ppb;
        w     = clamp_size(width_reg, MAX_WIDTH);
        if (first >= w) return 0;
        return (w - first > ppb) ? ppb : w - first;
    endfunction

    // palette index of pixel k of a byte, most significant first
    function automatic logic [7:0] pixel_index(logic [7:0] src, int unsigned k);
        case (bits_per_pixel())
            1:       return {7'd0, src[7 - k]};
            4:       return (k == 0) ? {4'd0, src[7:4]} : {4'd0, src[3:0]};
            default: return src;
        endcase
    endfunction

    // palette update or pixel expansion for one accepted transaction
    function automatic void expand_request(ipbe_pkg::t_req item);
        int unsigned    w, bits, stride, first, count, col, k;
        logic           img_last;
        logic [23:0]    rgb;
        ipbe_pkg::t_res px;
        if (item.req_type == ipbe_pkg::REQ_PAL) begin
            palette_copy[item.pal_index]    = {item.pal_red, item.pal_green, item.pal_blue};
            palette_written[item.pal_index] = 1'b1;
            return;
        end
        w        = clamp_size(width_reg, MAX_WIDTH);
        bits     = bits_per_pixel();
        stride   = ((w * bits + 31) / 32) * 4;
        first    = row_byte * (8 / bits);
        count    = pixels_in_byte();
        img_last = (row_index + 1 >= clamp_size(height_reg, MAX_HEIGHT));
        for (k = 0; k < count; k++) begin
            rgb          = palette_copy[pixel_index(item.src_byte, k)];
            col          = first + k;
            px.blue      = rgb[7:0];
            px.green     = rgb[15:8];
            px.red       = rgb[23:16];
            px.row_end   = (col == w - 1);
            px.image_end = (col == w - 1) && img_last;
            px.last      = (k + 1 == count);
            pending_pixels.push_back(px);
        end
        // padding bytes still move the row position on
        if (row_byte + 1 >= stride) begin
            row_byte  = '0;
            row_index = img_last ? '0 : 13'(row_index + 1);
        end else begin
            row_byte  = 12'(row_byte + 1);
        end
    endfunction

    // per item wait, with the odd stretch of back-to-back transactions
    function automatic int unsigned draw_gap(inout int unsigned calm_left);
        if (calm_left != 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = 15;
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    function automatic ipbe_pkg::t_req random_item(logic kind);
        ipbe_pkg::t_req item;
        item.req_type  = kind;
        item.pal_index = 8'($urandom);
        item.pal_red   = 8'($urandom);
        item.pal_green = 8'($urandom);
        item.pal_blue  = 8'($urandom);
        item.src_byte  = 8'($urandom);
        return item;
    endfunction

    // directed table construction
    function automatic void push_step(t_step_kind kind, logic [1:0] index,
                                      logic [12:0] data, ipbe_pkg::t_req item);
        t_directed_step step;
        step.kind        = kind;
        step.reg_index   = index;
        step.reg_data    = data;
        step.item        = item;
        step.use_typed   = 1'b0;
        step.typed_pixel = '0;
        directed_steps.push_back(step);
    endfunction

    function automatic void add_config(logic [1:0] index, logic [12:0] data);
        push_step(STEP_CONFIG, index, data, '0);
    endfunction

    function automatic void add_palette(logic [7:0] index, logic [7:0] red,
                                        logic [7:0] green, logic [7:0] blue);
        push_step(STEP_ITEM, '0, '0, {ipbe_pkg::REQ_PAL, index, red, green, blue, 8'h00});
    endfunction

    function automatic void add_byte(logic [7:0] src);
        push_step(STEP_ITEM, '0, '0, {ipbe_pkg::REQ_PIX, 32'h0, src});
    endfunction

    function automatic void add_checked_byte(logic [7:0] src, ipbe_pkg::t_res pixel);
        add_byte(src);
        directed_steps[directed_steps.size() - 1].use_typed   = 1'b1;
        directed_steps[directed_steps.size() - 1].typed_pixel = pixel;
    endfunction

    // offer one request transaction and predict once it is taken
    task automatic send_item(ipbe_pkg::t_req item);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        expand_request(item);
        items_sent++;
    endtask

    // hold off until every pixel is back, then let padding work retire
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [12:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= {index, data};
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (index)
            ipbe_pkg::CFG_DEPTH_MODE:   depth_reg  = data[1:0];
            ipbe_pkg::CFG_IMAGE_WIDTH:  width_reg  = data;
            ipbe_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
    endtask

    // result sink with random back-pressure
    initial begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_gap(recv_calm);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin : result_check
        ipbe_pkg::t_res want;
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;

        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected pixel: b=%02h g=%02h r=%02h row_end=%0b image_end=%0b last=%0b",
                             res_ch.data.blue, res_ch.data.green, res_ch.data.red,
                             res_ch.data.row_end, res_ch.data.image_end, res_ch.data.last);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (res_ch.data.blue !== want.blue || res_ch.data.green !== want.green ||
                    res_ch.data.red !== want.red || res_ch.data.row_end !== want.row_end ||
                    res_ch.data.image_end !== want.image_end ||
                    res_ch.data.last !== want.last) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("pixel mismatch: expected b=%02h g=%02h r=%02h re=%0b ie=%0b last=%0b",
                                 want.blue, want.green, want.red,
                                 want.row_end, want.image_end, want.last);
                        $display("                actual   b=%02h g=%02h r=%02h re=%0b ie=%0b last=%0b",
                                 res_ch.data.blue, res_ch.data.green, res_ch.data.red,
                                 res_ch.data.row_end, res_ch.data.image_end, res_ch.data.last);
                    end
                    mismatch_count++;
                end
            end
        end

        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_directed_step step;
        ipbe_pkg::t_req item;
        ipbe_pkg::t_req fill;
        logic [12:0]    data;
        logic [7:0]     idx;
        int unsigned    phase_len, count, n, k;

        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;

        // palette entries used below, extremes included
        add_palette(8'h00, 8'h00, 8'h00, 8'h00);
        add_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_palette(8'h01, 8'h12, 8'h34, 8'h56);
        add_palette(8'h0F, 8'hA5, 8'h5A, 8'hC3);
        add_palette(8'h80, 8'h80, 8'h01, 8'h7F);
        add_palette(8'hF0, 8'h3C, 8'hE1, 8'h0F);
        // reset settings: 8 bpp, one pixel per row and image, three padding bytes
        add_checked_byte(8'hFF, {8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1});
        add_byte(8'h5A);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_checked_byte(8'h00, {8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1});
        add_byte(8'h33);
        add_byte(8'hCC);
        add_byte(8'h80);
        // 1 bpp, 13 pixels: full byte, partial byte, then padding
        add_config(ipbe_pkg::CFG_DEPTH_MODE, 13'(ipbe_pkg::DEPTH_1BPP));
        add_config(ipbe_pkg::CFG_IMAGE_WIDTH, 13'd13);
        add_config(ipbe_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        add_byte(8'hA5);
        add_byte(8'h5A);
        add_byte(8'hFF);
        add_byte(8'h00);
        // 4 bpp, odd width: the last byte gives its high nibble only, image ends
        add_config(ipbe_pkg::CFG_DEPTH_MODE, 13'(ipbe_pkg::DEPTH_4BPP));
        add_config(ipbe_pkg::CFG_IMAGE_WIDTH, 13'd3);
        add_byte(8'h1F);
        add_byte(8'hF0);
        add_byte(8'h0F);
        add_byte(8'hF0);
        // spare depth code, zero sizes and a write to the unused index
        add_config(ipbe_pkg::CFG_DEPTH_MODE, {11'h7FF, DEPTH_MODE_SPARE});
        add_config(ipbe_pkg::CFG_IMAGE_WIDTH, 13'd0);
        add_config(ipbe_pkg::CFG_IMAGE_HEIGHT, 13'd0);
        add_config(CFG_UNUSED, 13'h1ABC);
        add_byte(8'h80);
        // saturated sizes, changed part way through a row
        add_config(ipbe_pkg::CFG_IMAGE_WIDTH, 13'(ipbe_pkg::CFG_MAX));
        add_config(ipbe_pkg::CFG_IMAGE_HEIGHT, 13'(ipbe_pkg::CFG_MAX));
        add_byte(8'hFF);
        add_byte(8'hF0);

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            step = directed_steps[i];
            if (step.kind == STEP_CONFIG) begin
                write_register(step.reg_index, step.reg_data);
            end else begin
                send_item(step.item);
                if (step.use_typed)
                    pending_pixels[pending_pixels.size() - 1] = step.typed_pixel;
            end
        end

        // random phases, row and image counters carry across settings
        while (items_sent < ITEM_TARGET) begin
            data      = 13'($urandom);
            data[1:0] = 2'($urandom_range(0, 3));
            write_register(ipbe_pkg::CFG_DEPTH_MODE, data);
            case ($urandom_range(0, 9))
                0:       data = '0;
                1:       data = 13'(ipbe_pkg::CFG_MAX);
                2:       data = 13'(MAX_WIDTH);
                3:       data = 13'd1;
                default: data = 13'($urandom_range(2, 40));
            endcase
            write_register(ipbe_pkg::CFG_IMAGE_WIDTH, data);
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = 13'(ipbe_pkg::CFG_MAX);
                default: data = 13'($urandom_range(1, 4));
            endcase
            write_register(ipbe_pkg::CFG_IMAGE_HEIGHT, data);

            phase_len = $urandom_range(20, 45);
            for (n = 0; n < phase_len && items_sent < ITEM_TARGET; n++) begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                if ($urandom_range(0, 4) == 0) begin
                    send_item(random_item(ipbe_pkg::REQ_PAL));
                end else begin
                    item  = random_item(ipbe_pkg::REQ_PIX);
                    count = pixels_in_byte();
                    // load any entry this byte reads that was never written
                    for (k = 0; k < count; k++) begin
                        idx = pixel_index(item.src_byte, k);
                        if (!palette_written[idx]) begin
                            fill           = random_item(ipbe_pkg::REQ_PAL);
                            fill.pal_index = idx;
                            send_item(fill);
                        end
                    end
                    send_item(item);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ipbe_pkg.sv
hdl/ipbe_stream_if.sv
hdl/ipbe_ram.sv
hdl/ipbe_front.sv
hdl/ipbe_fifo.sv
hdl/ipbe_back.sv
hdl/indexed_pixel_to_bgr_expander_unit.sv
bench/indexed_pixel_to_bgr_expander_unit_tb.sv
